// File: hw/rtl/dvc_pkg.sv
// ----------------------------------------------------------------------------
// dvc_pkg
// Shared types, codes and widths of the differential vector clock block.
// ----------------------------------------------------------------------------
package dvc_pkg;

  localparam int MAX_PROCS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 32;

  localparam int KIND_W     = 3;
  localparam int PIDX_W     = 8;
  localparam int VAL_W      = 32;
  localparam int OIDX_W     = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int OWN_ID_W   = 6;
  localparam int PCNT_W     = 7;

  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam kind_t KIND_TICK  = 3'd0;
  localparam kind_t KIND_MERGE = 3'd1;
  localparam kind_t KIND_SEND  = 3'd2;
  localparam kind_t KIND_DUMP  = 3'd3;
  localparam kind_t KIND_CMP   = 3'd4;

  localparam cfg_idx_t CFG_OWN_ID     = 1'b0;
  localparam cfg_idx_t CFG_PROC_COUNT = 1'b1;

  localparam logic [OWN_ID_W-1:0] OWN_ID_RESET = 6'd0;
  localparam logic [PCNT_W-1:0]   PCNT_RESET   = 7'd16;

  typedef enum logic [1:0] {
    ORD_EQUAL,
    ORD_BEFORE,
    ORD_AFTER,
    ORD_CONCURRENT
  } ord_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OWN,
    ST_WALK_RD,
    ST_WALK_EMIT,
    ST_FLUSH
  } dvc_state_t;

  function automatic ord_t order_of(input logic own_ng, input logic inc_ng);
    ord_t o;
    if (own_ng && inc_ng) begin
      o = ORD_EQUAL;
    end else if (own_ng) begin
      o = ORD_BEFORE;
    end else if (inc_ng) begin
      o = ORD_AFTER;
    end else begin
      o = ORD_CONCURRENT;
    end
    return o;
  endfunction

endpackage

// File: hw/rtl/dvc_if.sv
// ----------------------------------------------------------------------------
// dvc interfaces
// Request, result and register write channels of the vector clock block.
// ----------------------------------------------------------------------------
interface dvc_item_if;
  import dvc_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [PIDX_W-1:0]   proc_index;
  logic [VAL_W-1:0]    entry_value;
  logic                last_entry;

  modport source (output valid, kind, proc_index, entry_value, last_entry, input ready);
  modport sink   (input valid, kind, proc_index, entry_value, last_entry, output ready);
endinterface

interface dvc_result_if;
  import dvc_pkg::*;
  logic                valid;
  logic                ready;
  logic [OIDX_W-1:0]   out_index;
  logic [VAL_W-1:0]    out_value;
  logic                out_last;
  logic                is_order;
  logic [1:0]          order;

  modport source (output valid, out_index, out_value, out_last, is_order, order, input ready);
  modport sink   (input valid, out_index, out_value, out_last, is_order, order, output ready);
endinterface

interface dvc_cfg_if;
  import dvc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/differential_vector_clock.sv
// ----------------------------------------------------------------------------
// differential_vector_clock
// Vector clock of one process with differential send, dump and compare.
//
//   channel  modport  moves
//   item     sink     tick, merge, send, dump and compare requests
//   result   source   clock pairs and order results
//   cfg      sink     own_id and proc_count writes, always ready
//
// tick, compare, unused kinds and merges that store nothing or store the own
// entry go through EXEC alone, a merge into another entry also goes through OWN
// send and dump go through WALK_RD and WALK_EMIT per active entry, then FLUSH,
// as the entry memory has one read port and each entry needs a read and a check;
// a send to an inactive peer ends after EXEC; reset is synchronous; memory
// contents are masked by per-entry valid bits; a full result register stalls
// compare, send and dump; requests are not taken while one is in progress
// ----------------------------------------------------------------------------
module differential_vector_clock #(
  parameter int MAX_PROCS  = dvc_pkg::MAX_PROCS_DEF,
  parameter int COUNT_BITS = dvc_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  dvc_item_if.sink      item,
  dvc_result_if.source  result,
  dvc_cfg_if.sink       cfg
);
  import dvc_pkg::*;

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int NW = $clog2(MAX_PROCS + 1);
  localparam int CW = COUNT_BITS;
  localparam logic [VAL_W-1:0] CNT_MAX32 = VAL_W'((64'd1 << CW) - 64'd1);

  dvc_state_t state_q, state_next;

  logic [OWN_ID_W-1:0] own_id_q;
  logic [PCNT_W-1:0]   proc_count_q;

  kind_t               it_kind_q;
  logic [PIDX_W-1:0]   it_idx_q;
  logic [CW-1:0]       it_val_q;
  logic                it_last_q;

  logic [IW-1:0]       k_q;
  logic [CW-1:0]       own_q;
  logic                ong_q, ing_q;
  logic                stg_valid_q;
  logic [IW-1:0]       stg_idx_q;
  logic [CW-1:0]       stg_val_q;

  logic                out_valid_q;
  logic [OIDX_W-1:0]   out_index_q;
  logic [VAL_W-1:0]    out_value_q;
  logic                out_last_q;
  logic                is_order_q;
  ord_t                order_q;

  logic [MAX_PROCS-1:0] a_vld_q, b_vld_q;
  logic                 a_hit_q, b_hit_q;

  logic [NW-1:0]       n_act;
  logic [IW-1:0]       me;
  logic [CW-1:0]       val_sat;
  kind_t               sel_kind;
  logic [PIDX_W-1:0]   sel_idx;
  logic [2*CW-1:0]     a_rdata;
  logic [CW-1:0]       b_rdata;
  logic [CW-1:0]       a_clk, a_upd, b_sent, clk_inc, val_inc;
  logic                idx_act, idx_is_me, val_gt, qual, last_k, out_free, accept;
  logic                cmp_ong, cmp_ing;

  logic [IW-1:0]       a_raddr, a_waddr;
  logic                a_we, b_we;
  logic [2*CW-1:0]     a_wdata;
  logic [IW-1:0]       b_waddr;

  logic                out_load;
  logic [OIDX_W-1:0]   out_index_next;
  logic [VAL_W-1:0]    out_value_next;
  logic                out_last_next;
  logic                is_order_next;
  ord_t                order_next;
  logic                k_clr, k_inc, own_cap, flag_we, ong_next, ing_next;
  logic                stg_clr, stg_load;

  // derived configuration
  always_comb begin
    if (proc_count_q == '0) begin
      n_act = NW'(1);
    end else if (proc_count_q > PCNT_W'(MAX_PROCS)) begin
      n_act = NW'(MAX_PROCS);
    end else begin
      n_act = NW'(proc_count_q);
    end
    if (PCNT_W'(own_id_q) < PCNT_W'(n_act)) begin
      me = IW'(own_id_q);
    end else begin
      me = IW'(n_act - NW'(1));
    end
  end

  assign val_sat  = (item.entry_value > CNT_MAX32) ? CNT_MAX32[CW-1:0]
                                                   : item.entry_value[CW-1:0];
  assign accept   = item.valid && item.ready;
  assign sel_kind = (state_q == ST_IDLE) ? kind_t'(item.kind) : it_kind_q;
  assign sel_idx  = (state_q == ST_IDLE) ? item.proc_index : it_idx_q;

  assign a_clk   = a_hit_q ? a_rdata[CW-1:0] : '0;
  assign a_upd   = a_hit_q ? a_rdata[2*CW-1:CW] : '0;
  assign b_sent  = b_hit_q ? b_rdata : '0;
  assign clk_inc = (a_clk == '1) ? a_clk : a_clk + CW'(1);
  assign val_inc = (it_val_q == '1) ? it_val_q : it_val_q + CW'(1);

  assign idx_act   = it_idx_q < PIDX_W'(n_act);
  assign idx_is_me = it_idx_q == PIDX_W'(me);
  assign val_gt    = it_val_q > a_clk;
  assign cmp_ong   = ong_q & ~(idx_act & (a_clk > it_val_q));
  assign cmp_ing   = ing_q & ~(idx_act & (it_val_q > a_clk));
  assign qual      = (it_kind_q == KIND_DUMP) || (k_q == me) || (b_sent < a_upd);
  assign last_k    = NW'(k_q) == (n_act - NW'(1));
  assign out_free  = !out_valid_q || result.ready;

  assign item.ready = (state_q == ST_IDLE);
  assign cfg.ready  = 1'b1;

  assign result.valid     = out_valid_q;
  assign result.out_index = out_index_q;
  assign result.out_value = out_value_q;
  assign result.out_last  = out_last_q;
  assign result.is_order  = is_order_q;
  assign result.order     = order_q;

  dvc_ram #(.WIDTH(2 * CW), .DEPTH(MAX_PROCS)) u_entry_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  dvc_ram #(.WIDTH(CW), .DEPTH(MAX_PROCS)) u_sent_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (own_q),
    .raddr (sel_idx[IW-1:0]),
    .rdata (b_rdata)
  );

  // next state
  always_comb begin
    state_next = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (it_kind_q)
          KIND_MERGE: state_next = (idx_act && val_gt && !idx_is_me) ? ST_OWN : ST_IDLE;
          KIND_SEND:  state_next = idx_act ? ST_WALK_RD : ST_IDLE;
          KIND_DUMP:  state_next = ST_WALK_RD;
          KIND_CMP:   state_next = (it_last_q && !out_free) ? ST_EXEC : ST_IDLE;
          default:    state_next = ST_IDLE;
        endcase
      end
      ST_OWN:     state_next = ST_IDLE;
      ST_WALK_RD: state_next = ST_WALK_EMIT;
      ST_WALK_EMIT: begin
        if (qual && stg_valid_q && !out_free) begin
          state_next = ST_WALK_EMIT;
        end else if (last_k) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_WALK_RD;
        end
      end
      ST_FLUSH: begin
        if (!stg_valid_q || out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    a_raddr        = sel_idx[IW-1:0];
    a_we           = 1'b0;
    a_waddr        = me;
    a_wdata        = '0;
    b_we           = 1'b0;
    b_waddr        = it_idx_q[IW-1:0];
    out_load       = 1'b0;
    out_index_next = '0;
    out_value_next = '0;
    out_last_next  = 1'b0;
    is_order_next  = 1'b0;
    order_next     = ORD_EQUAL;
    k_clr          = 1'b0;
    k_inc          = 1'b0;
    own_cap        = 1'b0;
    flag_we        = 1'b0;
    ong_next       = ong_q;
    ing_next       = ing_q;
    stg_clr        = 1'b0;
    stg_load       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (sel_kind == KIND_TICK || sel_kind == KIND_SEND) a_raddr = me;
      end
      ST_EXEC: begin
        if (it_kind_q != KIND_CMP) a_raddr = me;
        case (it_kind_q)
          KIND_TICK: begin
            a_we    = 1'b1;
            a_wdata = {clk_inc, clk_inc};
          end
          KIND_MERGE: begin
            if (idx_act && val_gt && idx_is_me) begin
              a_we    = 1'b1;
              a_wdata = {val_inc, it_val_q};
            end
          end
          KIND_SEND: begin
            own_cap = 1'b1;
            k_clr   = 1'b1;
            stg_clr = 1'b1;
          end
          KIND_DUMP: begin
            k_clr   = 1'b1;
            stg_clr = 1'b1;
          end
          KIND_CMP: begin
            if (!it_last_q) begin
              flag_we  = 1'b1;
              ong_next = cmp_ong;
              ing_next = cmp_ing;
            end else if (out_free) begin
              out_load      = 1'b1;
              out_last_next = 1'b1;
              is_order_next = 1'b1;
              order_next    = order_of(cmp_ong, cmp_ing);
              flag_we       = 1'b1;
              ong_next      = 1'b1;
              ing_next      = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_OWN: begin
        a_raddr = me;
        a_we    = 1'b1;
        a_waddr = it_idx_q[IW-1:0];
        a_wdata = {clk_inc, it_val_q};
      end
      ST_WALK_RD: begin
        a_raddr = k_q;
      end
      ST_WALK_EMIT: begin
        a_raddr = k_q;
        if (!(qual && stg_valid_q && !out_free)) begin
          if (qual) begin
            stg_load = 1'b1;
            if (stg_valid_q) begin
              out_load       = 1'b1;
              out_index_next = OIDX_W'(stg_idx_q);
              out_value_next = VAL_W'(stg_val_q);
            end
          end
          k_inc = !last_k;
        end
      end
      ST_FLUSH: begin
        a_raddr = k_q;
        if (!stg_valid_q || out_free) begin
          out_load       = stg_valid_q;
          out_index_next = OIDX_W'(stg_idx_q);
          out_value_next = VAL_W'(stg_val_q);
          out_last_next  = 1'b1;
          stg_clr        = 1'b1;
          b_we           = (it_kind_q == KIND_SEND);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_q      <= ST_IDLE;
      own_id_q     <= OWN_ID_RESET;
      proc_count_q <= PCNT_RESET;
      ong_q        <= 1'b1;
      ing_q        <= 1'b1;
      stg_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      a_vld_q      <= '0;
      b_vld_q      <= '0;
    end else begin
      state_q <= state_next;
      if (cfg.valid && cfg.ready) begin
        case (cfg_idx_t'(cfg.index))
          CFG_OWN_ID:     own_id_q     <= cfg.data[OWN_ID_W-1:0];
          CFG_PROC_COUNT: proc_count_q <= cfg.data[PCNT_W-1:0];
          default: ;
        endcase
      end
      if (flag_we) begin
        ong_q <= ong_next;
        ing_q <= ing_next;
      end
      if (stg_clr) begin
        stg_valid_q <= 1'b0;
      end else if (stg_load) begin
        stg_valid_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result.ready) begin
        out_valid_q <= 1'b0;
      end
      if (a_we) a_vld_q[a_waddr] <= 1'b1;
      if (b_we) b_vld_q[b_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    a_hit_q <= a_vld_q[a_raddr];
    b_hit_q <= b_vld_q[sel_idx[IW-1:0]];
    if (accept) begin
      it_kind_q <= kind_t'(item.kind);
      it_idx_q  <= item.proc_index;
      it_val_q  <= val_sat;
      it_last_q <= item.last_entry;
    end
    if (k_clr) begin
      k_q <= '0;
    end else if (k_inc) begin
      k_q <= k_q + IW'(1);
    end
    if (own_cap) own_q <= a_clk;
    if (stg_load) begin
      stg_idx_q <= k_q;
      stg_val_q <= a_clk;
    end
    if (out_load) begin
      out_index_q <= out_index_next;
      out_value_q <= out_value_next;
      out_last_q  <= out_last_next;
      is_order_q  <= is_order_next;
      order_q     <= order_next;
    end
  end

`ifndef SYNTHESIS
  a_cmp_rearm: assert property (@(posedge clk) disable iff (rst)
    (state_q == ST_EXEC && it_kind_q == KIND_CMP && it_last_q && out_free)
    |=> (ong_q && ing_q))
    else $error("compare flags not rearmed after order result");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid_q) |-> $past(state_q) != ST_IDLE)
    else $error("result loaded while idle");

  a_walk_nowr: assert property (@(posedge clk) disable iff (rst)
    (state_q == ST_WALK_RD || state_q == ST_WALK_EMIT) |-> (!a_we && !b_we))
    else $error("memory write during entry walk");
`endif

endmodule

// File: hw/rtl/dvc_ram.sv
// ----------------------------------------------------------------------------
// dvc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
